// ===== hdl/pli_pkg.sv =====
// Shared types and codes for the packed list block.
`timescale 1ns / 1ps
package pli_pkg;

  typedef enum logic [4:0] {
    OP_INS_AT      = 5'd0,
    OP_INS_START   = 5'd1,
    OP_INS_END     = 5'd2,
    OP_INS_BEFORE  = 5'd3,
    OP_INS_AFTER   = 5'd4,
    OP_DEL_AT      = 5'd5,
    OP_DEL_START   = 5'd6,
    OP_DEL_END     = 5'd7,
    OP_DEL_VALUE   = 5'd8,
    OP_DEL_BEFORE  = 5'd9,
    OP_DEL_AFTER   = 5'd10,
    OP_DEL_ALL     = 5'd11,
    OP_UPD_AT      = 5'd12,
    OP_UPD_START   = 5'd13,
    OP_UPD_END     = 5'd14,
    OP_UPD_BEFORE  = 5'd15,
    OP_UPD_AFTER   = 5'd16,
    OP_UPD_ALL     = 5'd17,
    OP_FIND        = 5'd18,
    OP_READ_AT     = 5'd19,
    OP_FIND_BEFORE = 5'd20,
    OP_FIND_AFTER  = 5'd21,
    OP_CLEAR       = 5'd22
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_FULL     = 3'd2,
    ST_BADIDX   = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_NONEIGH  = 3'd5
  } status_e;

  // Per-cycle command broadcast to every cell.
  typedef enum logic [2:0] {
    CC_HOLD    = 3'd0,
    CC_INSERT  = 3'd1,
    CC_DELETE  = 3'd2,
    CC_WRITE   = 3'd3,
    CC_UPD_ALL = 3'd4,
    CC_COMPACT = 3'd5
  } cell_cmd_e;

endpackage

// ===== hdl/pli_if.sv =====
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface pli_req_if;
  logic        valid;
  logic        ready;
  logic [4:0]  op;
  logic signed [31:0] key_value;
  logic signed [31:0] new_value;
  logic [6:0]  position;
  modport source (output valid, op, key_value, new_value, position, input ready);
  modport sink   (input valid, op, key_value, new_value, position, output ready);
endinterface

interface pli_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [6:0]  found_index;
  logic signed [31:0] found_value;
  logic [7:0]  occupancy;
  modport source (output valid, status, found_index, found_value, occupancy, input ready);
  modport sink   (input valid, status, found_index, found_value, occupancy, output ready);
endinterface

// ===== hdl/pli_cell.sv =====
// One list cell: holds a word, shifts with neighbors, compares against the key.
`timescale 1ns / 1ps
module pli_cell #(
  parameter int WW = 32,
  parameter int IW = 7
) (
  input  logic                clk_i,
  input  pli_pkg::cell_cmd_e  cmd_i,
  input  logic [IW-1:0]       idx_i,
  input  logic [IW-1:0]       tgt_i,
  input  logic [WW-1:0]       key_i,
  input  logic [WW-1:0]       wdata_i,
  input  logic [WW-1:0]       left_i,
  input  logic [WW-1:0]       right_i,
  input  logic                comp_sel_i,
  output logic [WW-1:0]       word_o,
  output logic                match_o
);
  logic [WW-1:0] word_q, word_d;

  assign word_o  = word_q;
  assign match_o = (word_q == key_i);

  always_comb begin
    word_d = word_q;
    case (cmd_i)
      pli_pkg::CC_INSERT: begin
        if (idx_i == tgt_i) word_d = wdata_i;
        else if (idx_i > tgt_i) word_d = left_i;
      end
      pli_pkg::CC_DELETE: begin
        if (idx_i >= tgt_i) word_d = right_i;
      end
      pli_pkg::CC_WRITE: begin
        if (idx_i == tgt_i) word_d = wdata_i;
      end
      pli_pkg::CC_UPD_ALL: begin
        if (match_o) word_d = wdata_i;
      end
      pli_pkg::CC_COMPACT: begin
        if (comp_sel_i) word_d = right_i;
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end
endmodule

// ===== hdl/packed_list_insert_delete_search.sv =====
// Top level of the packed list with insert, delete, update and search.
`timescale 1ns / 1ps
// A gap-free list of up to DEPTH words held in a row of cells that compare
// against the key in parallel and shift toward their neighbors. A request is
// captured in S_IDLE and executed in S_EXEC; the first match is found by a
// priority search over the match vector and the result is registered. del_all
// compacts in S_COMPACT, removing one matching word per cycle until no match
// is left. A result waits in the output register until taken; the next
// request is accepted from the cycle after it has been taken.
module packed_list_insert_delete_search #(
  parameter int DEPTH      = 128,
  parameter int WORD_WIDTH = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  pli_req_if.sink   req,
  pli_rsp_if.source rsp
);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_COMPACT, S_RESP} state_e;

  state_e state_q;
  logic [CW-1:0] cnt_q;
  logic [4:0] op_q;
  logic [WORD_WIDTH-1:0] key_q, nv_q;
  logic [6:0] pos_q;
  logic [2:0] st_q;
  logic [6:0] fidx_q;
  logic [31:0] fval_q;

  logic [WORD_WIDTH-1:0] words [DEPTH];
  logic [DEPTH-1:0] match, mvalid, csel;

  pli_pkg::cell_cmd_e cmd;
  logic [IW-1:0] tgt;
  logic [WORD_WIDTH-1:0] wdata;

  function automatic logic [WORD_WIDTH-1:0] key_fold(input logic [31:0] v);
    logic [63:0] x;
    x = {{32{v[31]}}, v};
    return x[WORD_WIDTH-1:0];
  endfunction

  // first match and first-match-based compaction selects
  logic          hit;
  logic [IW-1:0] mi;
  always_comb begin
    hit = 1'b0;
    mi  = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (mvalid[i]) begin
        hit = 1'b1;
        mi  = IW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      mvalid[i] = match[i] && (CW'(i) < cnt_q);
      csel[i]   = hit && (IW'(i) >= mi);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    pli_cell #(.WW(WORD_WIDTH), .IW(IW)) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .idx_i     (IW'(g)),
      .tgt_i     (tgt),
      .key_i     (key_q),
      .wdata_i   (wdata),
      .left_i    ((g == 0) ? words[0] : words[(g == 0) ? 0 : g - 1]),
      .right_i   ((g == DEPTH - 1) ? words[g] : words[(g == DEPTH - 1) ? g : g + 1]),
      .comp_sel_i(csel[g]),
      .word_o    (words[g]),
      .match_o   (match[g])
    );
  end

  // decode in S_EXEC and S_COMPACT
  logic [2:0]  st;
  logic [6:0]  fidx;
  logic [31:0] fval;
  logic [CW-1:0] cnt_d;
  logic go_compact;
  logic [IW-1:0] t;
  logic [WORD_WIDTH-1:0] rd;
  logic [WORD_WIDTH+31:0] rdx;

  always_comb begin
    cmd = pli_pkg::CC_HOLD;
    tgt = '0;
    wdata = nv_q;
    st = pli_pkg::ST_OK;
    fidx = '0;
    fval = '0;
    cnt_d = cnt_q;
    go_compact = 1'b0;
    t = mi;
    rd = '0;
    rdx = '0;
    if (state_q == S_COMPACT) begin
      if (hit) begin
        cmd = pli_pkg::CC_COMPACT;
        cnt_d = cnt_q - CW'(1);
      end
    end else if (state_q == S_EXEC) begin
      if (op_q <= pli_pkg::OP_INS_AFTER) begin
        if (cnt_q >= CW'(DEPTH)) st = pli_pkg::ST_FULL;
        else if (op_q == pli_pkg::OP_INS_AT) begin
          if (32'(pos_q) > 32'(cnt_q)) st = pli_pkg::ST_BADIDX;
          else begin cmd = pli_pkg::CC_INSERT; tgt = IW'(pos_q); wdata = key_q; end
        end else if (op_q == pli_pkg::OP_INS_START) begin
          cmd = pli_pkg::CC_INSERT; tgt = '0; wdata = key_q;
        end else if (op_q == pli_pkg::OP_INS_END) begin
          cmd = pli_pkg::CC_INSERT; tgt = IW'(cnt_q); wdata = key_q;
        end else if (cnt_q == '0) st = pli_pkg::ST_EMPTY;
        else if (!hit) st = pli_pkg::ST_NOTFOUND;
        else begin
          cmd = pli_pkg::CC_INSERT;
          tgt = (op_q == pli_pkg::OP_INS_AFTER) ? mi + IW'(1) : mi;
        end
        if (cmd == pli_pkg::CC_INSERT) cnt_d = cnt_q + CW'(1);
      end else if (op_q <= pli_pkg::OP_FIND_AFTER) begin
        if (cnt_q == '0) st = pli_pkg::ST_EMPTY;
        else if (op_q == pli_pkg::OP_DEL_AT || op_q == pli_pkg::OP_UPD_AT ||
                 op_q == pli_pkg::OP_READ_AT) begin
          if (32'(pos_q) >= 32'(cnt_q)) st = pli_pkg::ST_BADIDX;
          else begin
            tgt = IW'(pos_q);
            if (op_q == pli_pkg::OP_DEL_AT) cmd = pli_pkg::CC_DELETE;
            else if (op_q == pli_pkg::OP_UPD_AT) begin
              cmd = pli_pkg::CC_WRITE; wdata = key_q;
            end else begin
              fidx = pos_q;
              rd = words[IW'(pos_q)];
            end
          end
        end else if (op_q == pli_pkg::OP_DEL_START) begin
          cmd = pli_pkg::CC_DELETE; tgt = '0;
        end else if (op_q == pli_pkg::OP_DEL_END) begin
          cmd = pli_pkg::CC_DELETE; tgt = IW'(cnt_q - CW'(1));
        end else if (op_q == pli_pkg::OP_UPD_START) begin
          cmd = pli_pkg::CC_WRITE; tgt = '0; wdata = key_q;
        end else if (op_q == pli_pkg::OP_UPD_END) begin
          cmd = pli_pkg::CC_WRITE; tgt = IW'(cnt_q - CW'(1)); wdata = key_q;
        end else if (!hit) st = pli_pkg::ST_NOTFOUND;
        else begin
          if (op_q == pli_pkg::OP_DEL_BEFORE || op_q == pli_pkg::OP_UPD_BEFORE ||
              op_q == pli_pkg::OP_FIND_BEFORE) begin
            if (mi == '0) st = pli_pkg::ST_NONEIGH; else t = mi - IW'(1);
          end else if (op_q == pli_pkg::OP_DEL_AFTER || op_q == pli_pkg::OP_UPD_AFTER ||
                       op_q == pli_pkg::OP_FIND_AFTER) begin
            if (CW'(mi) + CW'(1) >= cnt_q) st = pli_pkg::ST_NONEIGH;
            else t = mi + IW'(1);
          end
          if (st == pli_pkg::ST_OK) begin
            tgt = t;
            if (op_q == pli_pkg::OP_DEL_VALUE || op_q == pli_pkg::OP_DEL_BEFORE ||
                op_q == pli_pkg::OP_DEL_AFTER) cmd = pli_pkg::CC_DELETE;
            else if (op_q == pli_pkg::OP_UPD_BEFORE || op_q == pli_pkg::OP_UPD_AFTER)
              cmd = pli_pkg::CC_WRITE;
            else if (op_q == pli_pkg::OP_DEL_ALL) go_compact = 1'b1;
            else if (op_q == pli_pkg::OP_UPD_ALL) cmd = pli_pkg::CC_UPD_ALL;
            else begin
              fidx = 7'(t);
              rd = words[t];
            end
          end
        end
        if (cmd == pli_pkg::CC_DELETE) cnt_d = cnt_q - CW'(1);
      end else if (op_q == pli_pkg::OP_CLEAR) cnt_d = '0;
      rdx = {{32{rd[WORD_WIDTH-1]}}, rd};
      fval = rdx[31:0];
      if (st != pli_pkg::ST_OK) begin fidx = '0; fval = '0; end
    end
  end

  assign req.ready        = (state_q == S_IDLE);
  assign rsp.valid        = (state_q == S_RESP);
  assign rsp.status       = st_q;
  assign rsp.found_index  = fidx_q;
  assign rsp.found_value  = fval_q;
  assign rsp.occupancy    = 8'(cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      op_q    <= '0;
      key_q   <= '0;
      nv_q    <= '0;
      pos_q   <= '0;
      st_q    <= '0;
      fidx_q  <= '0;
      fval_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req.valid) begin
            op_q    <= req.op;
            key_q   <= key_fold(req.key_value);
            nv_q    <= key_fold(req.new_value);
            pos_q   <= req.position;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          st_q   <= st;
          fidx_q <= fidx;
          fval_q <= fval;
          cnt_q  <= cnt_d;
          state_q <= go_compact ? S_COMPACT : S_RESP;
        end
        S_COMPACT: begin
          cnt_q <= cnt_d;
          if (!hit) state_q <= S_RESP;
        end
        S_RESP: begin
          if (rsp.ready) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== tb/sv/tb_packed_list_insert_delete_search.sv =====
// Testbench for the packed list: scoreboard against an in-bench list model.
`timescale 1ns / 1ps
module tb_packed_list_insert_delete_search;

  localparam int LIST_DEPTH = 128;
  localparam logic [4:0] OP_SPARE_LO = 5'd23;
  localparam logic [4:0] OP_SPARE_HI = 5'd31;

  typedef struct packed {
    logic [2:0]  status;
    logic [6:0]  found_index;
    logic [31:0] found_value;
    logic [7:0]  occupancy;
  } list_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pli_req_if req_if ();
  pli_rsp_if rsp_if ();

  packed_list_insert_delete_search #(
    .DEPTH(LIST_DEPTH),
    .WORD_WIDTH(32)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req_if),
    .rsp   (rsp_if)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [31:0] list_mem [LIST_DEPTH];
  int          list_count = 0;
  list_rsp_t   pending_rsp[$];
  int          err_count = 0;
  int          send_idle_pct = 17;
  int          recv_idle_pct = 50;
  logic [31:0] key_pool [8];

  function automatic int first_hit(logic [31:0] key);
    for (int i = 0; i < list_count; i++) begin
      if (list_mem[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic void list_insert(int idx, logic [31:0] w);
    for (int i = list_count; i > idx; i--) list_mem[i] = list_mem[i-1];
    list_mem[idx] = w;
    list_count++;
  endfunction

  function automatic void list_remove(int idx);
    for (int i = idx; i + 1 < list_count; i++) list_mem[i] = list_mem[i+1];
    list_count--;
  endfunction

  function automatic list_rsp_t apply_request(logic [4:0] op, logic [31:0] key,
                                              logic [31:0] nv, logic [6:0] pos);
    list_rsp_t r;
    int n;
    int m;
    int t;
    int k;
    logic is_before;
    logic is_after;
    r = '0;
    r.status = pli_pkg::ST_OK;
    n = list_count;
    if (op <= pli_pkg::OP_INS_AFTER) begin
      if (n >= LIST_DEPTH) r.status = pli_pkg::ST_FULL;
      else if (op == pli_pkg::OP_INS_AT) begin
        if (pos > n) r.status = pli_pkg::ST_BADIDX;
        else list_insert(pos, key);
      end else if (op == pli_pkg::OP_INS_START) list_insert(0, key);
      else if (op == pli_pkg::OP_INS_END) list_insert(n, key);
      else if (n == 0) r.status = pli_pkg::ST_EMPTY;
      else begin
        m = first_hit(key);
        if (m < 0) r.status = pli_pkg::ST_NOTFOUND;
        else list_insert(m + ((op == pli_pkg::OP_INS_AFTER) ? 1 : 0), nv);
      end
    end else if (op <= pli_pkg::OP_FIND_AFTER) begin
      if (n == 0) r.status = pli_pkg::ST_EMPTY;
      else if (op == pli_pkg::OP_DEL_AT || op == pli_pkg::OP_UPD_AT ||
               op == pli_pkg::OP_READ_AT) begin
        if (pos >= n) r.status = pli_pkg::ST_BADIDX;
        else if (op == pli_pkg::OP_DEL_AT) list_remove(pos);
        else if (op == pli_pkg::OP_UPD_AT) list_mem[pos] = key;
        else begin
          r.found_index = pos;
          r.found_value = list_mem[pos];
        end
      end else if (op == pli_pkg::OP_DEL_START) list_remove(0);
      else if (op == pli_pkg::OP_DEL_END) list_remove(n - 1);
      else if (op == pli_pkg::OP_UPD_START) list_mem[0] = key;
      else if (op == pli_pkg::OP_UPD_END) list_mem[n-1] = key;
      else begin
        m = first_hit(key);
        if (m < 0) r.status = pli_pkg::ST_NOTFOUND;
        else begin
          is_before = (op == pli_pkg::OP_DEL_BEFORE || op == pli_pkg::OP_UPD_BEFORE ||
                       op == pli_pkg::OP_FIND_BEFORE);
          is_after  = (op == pli_pkg::OP_DEL_AFTER || op == pli_pkg::OP_UPD_AFTER ||
                       op == pli_pkg::OP_FIND_AFTER);
          t = m;
          if (is_before) begin
            if (m == 0) r.status = pli_pkg::ST_NONEIGH;
            else t = m - 1;
          end else if (is_after) begin
            if (m + 1 >= n) r.status = pli_pkg::ST_NONEIGH;
            else t = m + 1;
          end
          if (r.status == pli_pkg::ST_OK) begin
            if (op == pli_pkg::OP_DEL_VALUE || op == pli_pkg::OP_DEL_BEFORE ||
                op == pli_pkg::OP_DEL_AFTER) begin
              list_remove(t);
            end else if (op == pli_pkg::OP_UPD_BEFORE || op == pli_pkg::OP_UPD_AFTER) begin
              list_mem[t] = nv;
            end else if (op == pli_pkg::OP_DEL_ALL) begin
              k = 0;
              for (int i = 0; i < n; i++) begin
                if (list_mem[i] != key) begin
                  list_mem[k] = list_mem[i];
                  k++;
                end
              end
              list_count = k;
            end else if (op == pli_pkg::OP_UPD_ALL) begin
              for (int i = m; i < n; i++) if (list_mem[i] == key) list_mem[i] = nv;
            end else begin
              r.found_index = 7'(t);
              r.found_value = list_mem[t];
            end
          end
        end
      end
    end else if (op == pli_pkg::OP_CLEAR) begin
      list_count = 0;
    end
    r.occupancy = 8'(list_count);
    return r;
  endfunction

  task automatic send_request(logic [4:0] op, logic [31:0] key, logic [31:0] nv,
                              logic [6:0] pos);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid     = 1'b1;
    req_if.op        = op;
    req_if.key_value = key;
    req_if.new_value = nv;
    req_if.position  = pos;
    do @(posedge clk_i); while (!req_if.ready);
    pending_rsp.push_back(apply_request(op, key, nv, pos));
    @(negedge clk_i);
    req_if.valid = 1'b0;
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    list_rsp_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected result status=%0d", $time, rsp_if.status);
        err_count++;
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_if.status !== want.status) begin
          $display("%0t: status exp %0d got %0d", $time, want.status, rsp_if.status);
          err_count++;
        end
        if (rsp_if.found_index !== want.found_index) begin
          $display("%0t: found_index exp %0d got %0d", $time, want.found_index,
                   rsp_if.found_index);
          err_count++;
        end
        if (rsp_if.found_value !== want.found_value) begin
          $display("%0t: found_value exp %h got %h", $time, want.found_value,
                   rsp_if.found_value);
          err_count++;
        end
        if (rsp_if.occupancy !== want.occupancy) begin
          $display("%0t: occupancy exp %0d got %0d", $time, want.occupancy,
                   rsp_if.occupancy);
          err_count++;
        end
      end
    end
  end

  function automatic logic [31:0] pick_key();
    if ($urandom_range(0, 99) < 75) return key_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic test_directed();
    send_request(pli_pkg::OP_CLEAR, 0, 0, 0);
    send_request(pli_pkg::OP_DEL_START, 0, 0, 0);
    send_request(pli_pkg::OP_FIND, 0, 0, 0);
    send_request(pli_pkg::OP_INS_BEFORE, 0, 5, 0);
    send_request(pli_pkg::OP_INS_AT, 32'h7fffffff, 0, 7'd1);
    send_request(pli_pkg::OP_INS_AT, 32'h80000000, 0, 7'd0);
    send_request(pli_pkg::OP_INS_END, 32'hffffffff, 0, 7'd127);
    send_request(pli_pkg::OP_INS_START, 0, 0, 0);
    send_request(pli_pkg::OP_INS_AFTER, 32'hffffffff, 32'h12345678, 0);
    send_request(pli_pkg::OP_INS_BEFORE, 32'h80000000, 32'hffffffff, 0);
    send_request(pli_pkg::OP_INS_AFTER, 32'h55, 1, 0);
    send_request(pli_pkg::OP_READ_AT, 0, 0, 7'd127);
    send_request(pli_pkg::OP_READ_AT, 0, 0, 7'd5);
    send_request(pli_pkg::OP_FIND_BEFORE, 0, 0, 0);
    send_request(pli_pkg::OP_FIND_AFTER, 32'h12345678, 0, 0);
    send_request(pli_pkg::OP_FIND_BEFORE, 32'h80000000, 0, 0);
    send_request(pli_pkg::OP_UPD_ALL, 32'hffffffff, 32'h7fffffff, 0);
    send_request(pli_pkg::OP_UPD_AT, 32'haaaa5555, 0, 7'd2);
    send_request(pli_pkg::OP_UPD_BEFORE, 32'haaaa5555, 32'h1, 0);
    send_request(pli_pkg::OP_DEL_ALL, 32'h7fffffff, 0, 0);
    send_request(pli_pkg::OP_DEL_AFTER, 0, 0, 0);
    send_request(pli_pkg::OP_DEL_AT, 0, 0, 7'd127);
    send_request(OP_SPARE_HI, 32'hffffffff, 32'hffffffff, 7'd127);
    send_request(pli_pkg::OP_DEL_END, 0, 0, 0);
    send_request(pli_pkg::OP_CLEAR, 0, 0, 0);
  endtask

  task automatic test_full_list();
    logic [4:0] op;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      send_request(pli_pkg::OP_INS_END, 32'(i[2:0]), 0, 0);
    end
    send_request(pli_pkg::OP_INS_AT, 0, 0, 7'd0);
    send_request(pli_pkg::OP_INS_START, 0, 0, 0);
    send_request(pli_pkg::OP_INS_BEFORE, 99, 0, 0);
    send_request(pli_pkg::OP_INS_AFTER, 3, 0, 0);
    send_request(pli_pkg::OP_READ_AT, 0, 0, 7'd127);
    send_request(pli_pkg::OP_FIND_AFTER, 7, 0, 0);
    for (int i = 0; i < 20; i++) begin
      op = 5'($urandom_range(pli_pkg::OP_DEL_AT, pli_pkg::OP_FIND_AFTER));
      send_request(op, $urandom_range(0, 7), $urandom_range(0, 7),
                   7'($urandom_range(0, 127)));
    end
    send_request(pli_pkg::OP_DEL_ALL, 2, 0, 0);
    send_request(pli_pkg::OP_CLEAR, 0, 0, 0);
  endtask

  task automatic test_random(int n_items);
    logic [4:0] op;
    logic [6:0] pos;
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h80000000;
    key_pool[1] = 32'h7fffffff;
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < 5) op = 5'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      else if ($urandom_range(0, 99) < 35) begin
        op = 5'($urandom_range(pli_pkg::OP_INS_AT, pli_pkg::OP_INS_AFTER));
      end else if ($urandom_range(0, 199) == 0) op = pli_pkg::OP_CLEAR;
      else op = 5'($urandom_range(pli_pkg::OP_DEL_AT, pli_pkg::OP_FIND_AFTER));
      if ($urandom_range(0, 99) < 80) pos = 7'($urandom_range(0, list_count));
      else pos = 7'($urandom_range(0, 127));
      send_request(op, pick_key(), pick_key(), pos);
    end
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.op = '0;
    req_if.key_value = '0;
    req_if.new_value = '0;
    req_if.position = '0;
    rsp_if.ready = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_full_list();
    test_random(500);
    send_idle_pct = 50;
    recv_idle_pct = 17;
    test_random(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_full_list();
    test_random(500);
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (err_count == 0 && pending_rsp.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pli_pkg.sv
hdl/pli_if.sv
hdl/pli_cell.sv
hdl/packed_list_insert_delete_search.sv
tb/sv/tb_packed_list_insert_delete_search.sv
